// ===== rtl/y2i_pkg.sv =====
package y2i_pkg;

	localparam int LUMA_W = 8;
	localparam int CHROMA_W = 8;
	localparam int WIDTH_W = 12;
	localparam int HEIGHT_W = 13;
	localparam int ROW_W = 12;
	localparam int CFG_DATA_W = 13;
	localparam int TDATA_W = 32;
	localparam int TUSER_W = 2;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

	typedef enum logic {
		REG_FRAME_WIDTH = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// position flags of the item at the head of the scan
	typedef struct packed {
		logic odd_line;
		logic end_of_line;
		logic end_of_frame;
	} scan_flags_t;

	function automatic logic [ROW_W-1:0] lines_m1(input logic [HEIGHT_W-1:0] h);
		logic [ROW_W-1:0] r;
		if (h == '0) begin
			r = '0;
		end else if (h > HEIGHT_LIMIT) begin
			r = ROW_W'(HEIGHT_LIMIT - 13'd1);
		end else begin
			r = ROW_W'(h - 13'd1);
		end
		return r;
	endfunction

endpackage

// ===== rtl/y2i_line_store.sv =====
module y2i_line_store
	import y2i_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [ADDR_W-1:0]        wr_addr,
	input  logic [2*CHROMA_W-1:0]    wr_data,
	input  logic                     rd_en,
	input  logic [ADDR_W-1:0]        rd_addr,
	output logic [2*CHROMA_W-1:0]    rd_data
);

	// V in the high byte, U in the low byte
	logic [2*CHROMA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/y2i_scan_ctl.sv =====
module y2i_scan_ctl
	import y2i_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  cfg_reg_t              cfg_reg,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  advance,
	output logic [ADDR_W-1:0]     column,
	output scan_flags_t           flags
);

	logic [ADDR_W-1:0] pairs_m1_q;
	logic [ROW_W-1:0]  lines_m1_q;
	logic [ADDR_W-1:0] col_q;
	logic [ROW_W-1:0]  row_q;

	// last pair index: width / 2 - 1, kept within 0 .. DEPTH - 1
	function automatic logic [ADDR_W-1:0] pairs_m1(input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-2:0] half;
		logic [31:0] h32;
		logic [ADDR_W-1:0] r;
		half = w[WIDTH_W-1:1];
		h32 = 32'(half);
		if (half == '0) begin
			r = '0;
		end else if (h32 > 32'(DEPTH)) begin
			r = ADDR_W'(DEPTH - 1);
		end else begin
			r = ADDR_W'(h32 - 32'd1);
		end
		return r;
	endfunction

	assign column = col_q;
	assign flags.odd_line = row_q[0];
	assign flags.end_of_line = (col_q == pairs_m1_q);
	assign flags.end_of_frame = (col_q == pairs_m1_q) && (row_q == lines_m1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_m1_q <= pairs_m1(WIDTH_RESET);
			lines_m1_q <= lines_m1(HEIGHT_RESET);
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_write) begin
			// any register write restarts the frame
			case (cfg_reg)
				REG_FRAME_WIDTH: pairs_m1_q <= pairs_m1(cfg_data[WIDTH_W-1:0]);
				REG_FRAME_HEIGHT: lines_m1_q <= lines_m1(cfg_data);
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (flags.end_of_line) begin
				col_q <= '0;
				row_q <= flags.end_of_frame ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/yuy2_to_i420_converter_top.sv =====
// YUY2 to 4:2:0 converter.
// Input stream (s_axis_*): one YUY2 macropixel per item, raster order, with
// tdata = {V, Y1, U, Y0} from the high byte down.
// Output stream (m_axis_*): one item per input item, in order. Luma passes
// through; on odd lines the chroma is the truncated mean of the stored even
// line and the current line, on even lines chroma_valid and both averages
// are zero. tlast marks the last pair of a line, tuser[1] the last pair of
// the frame.
// Configuration (cfg_*): index 0 frame width, index 1 frame height; a write
// restarts the frame. Write only while the block is idle. cfg_ready is
// always high.
// Pipeline: the accept edge loads stage 1 and reads the line store; the
// output register then takes the average when it advances.
// Throughput: one item per cycle while m_axis_tready is high; each item
// makes one line store access (a write on even lines, a read on odd lines).
// Reset: clears the scan position and loads 640 x 480; the line store is
// not cleared, since every entry is written on an even line before use.
// Stall: when the receiver holds m_axis_tready low, the output register
// holds its item, the first stage still takes one more item if it is empty,
// then s_axis_tready drops until the output drains.
module yuy2_to_i420_converter_top
	import y2i_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,  // 0 frame_width, 1 frame_height
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
	input  logic [TDATA_W-1:0]    s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] luma_out_first, [15:8] luma_out_second, [23:16] blue_average,
	// [31:24] red_average
	output logic [TDATA_W-1:0]    m_axis_tdata,
	output logic                  m_axis_tlast,   // end_of_line
	// [0] chroma_valid, [1] end_of_frame
	output logic [TUSER_W-1:0]    m_axis_tuser
);

	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W = $clog2(DEPTH);

	logic                  in_accept;
	logic                  load_s2;
	logic [ADDR_W-1:0]     column;
	scan_flags_t           flags;
	logic [2*CHROMA_W-1:0] stored;

	// stage 1: item with its scan position, line store access in flight
	logic                valid_s1;
	logic [LUMA_W-1:0]   y0_s1;
	logic [LUMA_W-1:0]   y1_s1;
	logic [CHROMA_W-1:0] u_s1;
	logic [CHROMA_W-1:0] v_s1;
	scan_flags_t         flags_s1;

	// stage 2: output register
	logic                valid_s2;
	logic [LUMA_W-1:0]   y0_s2;
	logic [LUMA_W-1:0]   y1_s2;
	logic                cvalid_s2;
	logic [CHROMA_W-1:0] uavg_s2;
	logic [CHROMA_W-1:0] vavg_s2;
	logic                eol_s2;
	logic                eof_s2;

	logic [CHROMA_W:0]   usum;
	logic [CHROMA_W:0]   vsum;

	assign cfg_ready = 1'b1;

	// advance the output register when empty or taken
	assign load_s2 = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || load_s2;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	y2i_scan_ctl #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_reg   (cfg_reg_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.advance   (in_accept),
		.column    (column),
		.flags     (flags)
	);

	// even lines store chroma, odd lines read it back; read data holds while
	// stage 1 holds, since a read is issued only on accept
	y2i_line_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (in_accept && !flags.odd_line),
		.wr_addr (column),
		.wr_data ({s_axis_tdata[31:24], s_axis_tdata[15:8]}),
		.rd_en   (in_accept && flags.odd_line),
		.rd_addr (column),
		.rd_data (stored)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			y0_s1 <= s_axis_tdata[7:0];
			u_s1 <= s_axis_tdata[15:8];
			y1_s1 <= s_axis_tdata[23:16];
			v_s1 <= s_axis_tdata[31:24];
			flags_s1 <= flags;
		end
	end

	assign usum = {1'b0, stored[CHROMA_W-1:0]} + {1'b0, u_s1};
	assign vsum = {1'b0, stored[2*CHROMA_W-1:CHROMA_W]} + {1'b0, v_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			y0_s2 <= y0_s1;
			y1_s2 <= y1_s1;
			cvalid_s2 <= flags_s1.odd_line;
			uavg_s2 <= flags_s1.odd_line ? usum[CHROMA_W:1] : '0;
			vavg_s2 <= flags_s1.odd_line ? vsum[CHROMA_W:1] : '0;
			eol_s2 <= flags_s1.end_of_line;
			eof_s2 <= flags_s1.end_of_frame;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {vavg_s2, uavg_s2, y1_s2, y0_s2};
	assign m_axis_tlast = eol_s2;
	assign m_axis_tuser = {eof_s2, cvalid_s2};

endmodule
